[sv/deq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue package
// Operation and error codes and the fixed index width shared by the queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int IDX_W = 6;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_READ       = 2'd2,
    OP_WRITE      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_RANGE = 2'd2
  } err_t;

endpackage

[sv/double_ended_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue
// Fixed-capacity deque over a ring store: push front/back, read/write by index.
// ----------------------------------------------------------------------------
// One operation per word is accepted each cycle in_ready is high, with its
// result registered the next cycle; a new word is taken whenever the result
// register is empty or being drained. Elements sit in a CAPACITY-deep ring
// memory with one write and one registered read per cycle, addressed from a
// head pointer. Front and back elements are tracked in side registers, so
// every result carries them without extra memory ports. A push into a full
// queue is dropped with a full error; checked access at or beyond the count
// gives a range error, unchecked access clamps to the last element. Empty
// queue reads and front/back values return zero.
module double_ended_queue #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  deq_pkg::op_t                      in_op,
  input  logic [deq_pkg::IDX_W-1:0]         in_index,
  input  logic [DATA_WIDTH-1:0]             in_value,
  input  logic                              in_checked,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [DATA_WIDTH-1:0]             out_read_data,
  output deq_pkg::err_t                     out_error,
  output logic [$clog2(CAPACITY+1)-1:0]     out_count,
  output logic                              out_is_empty,
  output logic [DATA_WIDTH-1:0]             out_front_value,
  output logic [DATA_WIDTH-1:0]             out_back_value
);
  import deq_pkg::*;

  localparam int PTR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LW    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam logic [PTR_W:0]   CAP_P    = CAPACITY[PTR_W:0];
  localparam logic [PTR_W-1:0] CAP_LAST = PTR_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [DATA_WIDTH-1:0] front_r, front_nxt;
  logic [DATA_WIDTH-1:0] back_r, back_nxt;

  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] rdata_r, rdata_nxt;
  logic                  use_mem_r, use_mem_nxt;
  logic [DATA_WIDTH-1:0] mem_q_r;
  err_t                  err_r, err_nxt;
  logic [CNT_W-1:0]      out_count_r;
  logic [DATA_WIDTH-1:0] out_front_r, out_back_r;

  logic                  accept;
  logic                  wr_en;
  logic [PTR_W-1:0]      wr_addr;
  logic [PTR_W-1:0]      rd_addr;
  logic                  full;
  logic                  access_ok;
  logic [LW-1:0]         idx_ext, last_ext, pos_ext;
  logic [PTR_W-1:0]      pos;
  logic [PTR_W-1:0]      pos_slot;

  // Ring position of a logical offset from a base slot.
  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                               input logic [PTR_W-1:0] ofs);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= CAP_P) begin
      sum = sum - CAP_P;
    end
    return sum[PTR_W-1:0];
  endfunction

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign full      = (count_r == CAP_CNT);
  assign idx_ext   = LW'(in_index);
  assign last_ext  = LW'(count_r) - LW'(1);
  assign access_ok = !(in_checked && (idx_ext >= LW'(count_r))) && (count_r != '0);
  // clamp to the last element
  assign pos_ext   = (idx_ext > last_ext) ? last_ext : idx_ext;
  assign pos       = pos_ext[PTR_W-1:0];
  assign pos_slot  = slot_of(head_r, pos);
  assign rd_addr   = pos_slot;

  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    front_nxt   = front_r;
    back_nxt    = back_r;
    wr_en       = 1'b0;
    wr_addr     = pos_slot;
    rdata_nxt   = '0;
    use_mem_nxt = 1'b0;
    err_nxt     = ERR_NONE;
    unique case (in_op)
      OP_PUSH_FRONT: begin
        if (full) begin
          err_nxt = ERR_FULL;
        end else begin
          head_nxt  = (head_r == '0) ? CAP_LAST : head_r - PTR_W'(1);
          wr_en     = 1'b1;
          wr_addr   = head_nxt;
          count_nxt = count_r + CNT_W'(1);
          front_nxt = in_value;
          if (count_r == '0) begin
            back_nxt = in_value;
          end
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          err_nxt = ERR_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = slot_of(head_r, count_r[PTR_W-1:0]);
          count_nxt = count_r + CNT_W'(1);
          back_nxt  = in_value;
          if (count_r == '0) begin
            front_nxt = in_value;
          end
        end
      end
      OP_READ: begin
        if (in_checked && (idx_ext >= LW'(count_r))) begin
          err_nxt = ERR_RANGE;
        end
        use_mem_nxt = access_ok;
      end
      OP_WRITE: begin
        if (in_checked && (idx_ext >= LW'(count_r))) begin
          err_nxt = ERR_RANGE;
        end
        if (access_ok) begin
          wr_en     = 1'b1;
          rdata_nxt = in_value;
          if (pos == '0) begin
            front_nxt = in_value;
          end
          if (pos_ext == last_ext) begin
            back_nxt = in_value;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (wr_en) begin
        mem[wr_addr] <= in_value;
      end
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      rdata_r     <= rdata_nxt;
      use_mem_r   <= use_mem_nxt;
      err_r       <= err_nxt;
      out_count_r <= count_nxt;
      // hold zero for an empty queue
      out_front_r <= (count_nxt == '0) ? '0 : front_nxt;
      out_back_r  <= (count_nxt == '0) ? '0 : back_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = use_mem_r ? mem_q_r : rdata_r;
  assign out_error       = err_r;
  assign out_count       = out_count_r;
  assign out_is_empty    = (out_count_r == '0);
  assign out_front_value = out_front_r;
  assign out_back_value  = out_back_r;

endmodule

[bench/double_ended_queue_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push front/back and indexed read/write words through the queue and
// checks each result against its typed row or a ring-buffer predictor. A short
// table covers the empty queue, range errors, clamping and the data extremes.
// The random part then fills the queue while mixing in indexed access, runs
// into the full case, and keeps going on the full queue. Both sides idle in
// short random bursts. The result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module double_ended_queue_test;
  import deq_pkg::*;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int N_RANDOM   = 1330;
  localparam int CALM_AFTER = 1250;
  localparam int HOLD_AT    = 400;
  localparam int HOLD_LEN   = 60;

  typedef struct packed {
    logic [31:0] read_data;
    err_t        error;
    logic [6:0]  count;
    logic        is_empty;
    logic [31:0] front_value;
    logic [31:0] back_value;
  } deq_result_t;

  typedef struct packed {
    op_t         op;
    logic [5:0]  index;
    logic [31:0] value;
    logic        checked;
    logic        typed;
    deq_result_t want;
  } stim_row_t;

  localparam deq_result_t PREDICTED = '0;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  op_t                   in_op;
  logic [IDX_W-1:0]      in_index;
  logic [DATA_WIDTH-1:0] in_value;
  logic                  in_checked;
  logic                  out_valid;
  logic                  out_ready;
  logic [DATA_WIDTH-1:0] out_read_data;
  err_t                  out_error;
  logic [6:0]            out_count;
  logic                  out_is_empty;
  logic [DATA_WIDTH-1:0] out_front_value;
  logic [DATA_WIDTH-1:0] out_back_value;

  // Typed expectation riding along with the word on the input side
  logic        use_typed;
  deq_result_t typed_result;

  // Predictor state
  logic [31:0] ring_mem [CAPACITY];
  logic [5:0]  head_q;
  logic [6:0]  depth_q;

  deq_result_t replies_due [$];
  int          fails;
  int          words_in;
  int          words_sent;
  bit          calm;

  stim_row_t directed_rows [19] = '{
    '{OP_READ,       6'd0,  32'h0,        1'b1, 1'b1,
      '{32'h0, ERR_RANGE, 7'd0, 1'b1, 32'h0, 32'h0}},
    '{OP_READ,       6'd63, 32'h0,        1'b0, 1'b1,
      '{32'h0, ERR_NONE, 7'd0, 1'b1, 32'h0, 32'h0}},
    '{OP_WRITE,      6'd5,  32'hDEADBEEF, 1'b1, 1'b1,
      '{32'h0, ERR_RANGE, 7'd0, 1'b1, 32'h0, 32'h0}},
    '{OP_WRITE,      6'd0,  32'hDEADBEEF, 1'b0, 1'b1,
      '{32'h0, ERR_NONE, 7'd0, 1'b1, 32'h0, 32'h0}},
    '{OP_PUSH_BACK,  6'd0,  32'hFFFFFFFF, 1'b0, 1'b1,
      '{32'h0, ERR_NONE, 7'd1, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF}},
    '{OP_PUSH_FRONT, 6'd63, 32'h0,        1'b1, 1'b1,
      '{32'h0, ERR_NONE, 7'd2, 1'b0, 32'h0, 32'hFFFFFFFF}},
    '{OP_READ,       6'd1,  32'h0,        1'b1, 1'b1,
      '{32'hFFFFFFFF, ERR_NONE, 7'd2, 1'b0, 32'h0, 32'hFFFFFFFF}},
    '{OP_READ,       6'd2,  32'h0,        1'b1, 1'b1,
      '{32'h0, ERR_RANGE, 7'd2, 1'b0, 32'h0, 32'hFFFFFFFF}},
    '{OP_READ,       6'd63, 32'h0,        1'b0, 1'b1,
      '{32'hFFFFFFFF, ERR_NONE, 7'd2, 1'b0, 32'h0, 32'hFFFFFFFF}},
    '{OP_WRITE,      6'd63, 32'hA5A5A5A5, 1'b0, 1'b1,
      '{32'hA5A5A5A5, ERR_NONE, 7'd2, 1'b0, 32'h0, 32'hA5A5A5A5}},
    '{OP_WRITE,      6'd0,  32'h5A5A5A5A, 1'b1, 1'b1,
      '{32'h5A5A5A5A, ERR_NONE, 7'd2, 1'b0, 32'h5A5A5A5A, 32'hA5A5A5A5}},
    '{OP_WRITE,      6'd63, 32'hFFFFFFFF, 1'b1, 1'b1,
      '{32'h0, ERR_RANGE, 7'd2, 1'b0, 32'h5A5A5A5A, 32'hA5A5A5A5}},
    '{OP_PUSH_FRONT, 6'd0,  32'h12345678, 1'b0, 1'b0, PREDICTED},
    '{OP_PUSH_BACK,  6'd0,  32'h87654321, 1'b1, 1'b0, PREDICTED},
    '{OP_READ,       6'd0,  32'h0,        1'b0, 1'b0, PREDICTED},
    '{OP_READ,       6'd3,  32'h0,        1'b1, 1'b0, PREDICTED},
    '{OP_WRITE,      6'd2,  32'h0,        1'b0, 1'b0, PREDICTED},
    '{OP_READ,       6'd4,  32'h0,        1'b1, 1'b0, PREDICTED},
    '{OP_READ,       6'd42, 32'h0,        1'b0, 1'b0, PREDICTED}
  };

  double_ended_queue #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_index        (in_index),
    .in_value        (in_value),
    .in_checked      (in_checked),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_data   (out_read_data),
    .out_error       (out_error),
    .out_count       (out_count),
    .out_is_empty    (out_is_empty),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Apply one operation to the ring and return the status it reports
  function automatic deq_result_t deque_apply(op_t op, logic [5:0] idx,
                                              logic [31:0] val, logic chk);
    deq_result_t r;
    logic [5:0]  pos;
    logic [5:0]  slot;
    r = '0;
    r.error = ERR_NONE;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (depth_q == 7'(CAPACITY)) begin
          r.error = ERR_FULL;
        end else if (op == OP_PUSH_FRONT) begin
          head_q = head_q - 6'd1;
          ring_mem[head_q] = val;
          depth_q = depth_q + 7'd1;
        end else begin
          slot = head_q + depth_q[5:0];
          ring_mem[slot] = val;
          depth_q = depth_q + 7'd1;
        end
      end
      default: begin
        if (chk && ({1'b0, idx} >= depth_q)) begin
          r.error = ERR_RANGE;
        end else if (depth_q != 7'd0) begin
          // clamp to the last element
          pos = ({1'b0, idx} >= depth_q) ? depth_q[5:0] - 6'd1 : idx;
          slot = head_q + pos;
          if (op == OP_WRITE) ring_mem[slot] = val;
          r.read_data = ring_mem[slot];
        end
      end
    endcase
    r.count = depth_q;
    r.is_empty = (depth_q == 7'd0);
    if (depth_q != 7'd0) begin
      slot = head_q + depth_q[5:0] - 6'd1;
      r.front_value = ring_mem[head_q];
      r.back_value = ring_mem[slot];
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : monitor
    deq_result_t r;
    deq_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        r = deque_apply(in_op, in_index, in_value, in_checked);
        replies_due = {replies_due, (use_typed ? typed_result : r)};
        words_in++;
      end
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result word with nothing expected", $time);
          fails++;
        end else begin
          want = replies_due.pop_front();
          check_field("read_data", want.read_data, out_read_data);
          check_field("error", 32'(want.error), 32'(out_error));
          check_field("count", 32'(want.count), 32'(out_count));
          check_field("is_empty", 32'(want.is_empty), 32'(out_is_empty));
          check_field("front_value", want.front_value, out_front_value);
          check_field("back_value", want.back_value, out_back_value);
        end
      end
    end
  end

  // Offer one word, optionally after an idle burst, and hold it until taken
  task automatic send_word(op_t op, logic [5:0] idx, logic [31:0] val, logic chk,
                           logic typed, deq_result_t want);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_index     <= idx;
    in_value     <= val;
    in_checked   <= chk;
    use_typed    <= typed;
    typed_result <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (words_sent >= CALM_AFTER) calm = 1'b1;
  endtask

  // Result side: random stalls, one long hold-off, none near the end
  initial begin : receiver
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && words_in >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  initial begin : sender
    int          gen_depth;
    int          near;
    op_t         op;
    logic [5:0]  idx;
    logic [31:0] val;
    head_q     = '0;
    depth_q    = '0;
    fails      = 0;
    words_in   = 0;
    words_sent = 0;
    calm       = 1'b0;
    gen_depth  = 0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_op        <= OP_PUSH_FRONT;
    in_index     <= '0;
    in_value     <= '0;
    in_checked   <= 1'b0;
    use_typed    <= 1'b0;
    typed_result <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].op, directed_rows[i].index, directed_rows[i].value,
                directed_rows[i].checked, directed_rows[i].typed, directed_rows[i].want);
      if (directed_rows[i].op inside {OP_PUSH_FRONT, OP_PUSH_BACK}) gen_depth++;
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      val = ($urandom_range(0, 15) == 0) ? ($urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h0)
                                         : $urandom();
      if (gen_depth < CAPACITY) begin
        // fill phase: one push in three, indexes often near the boundary
        if ($urandom_range(0, 2) == 0) begin
          op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end else begin
          op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
        end
        if ($urandom_range(0, 1)) begin
          idx = 6'($urandom_range(0, 63));
        end else begin
          near = gen_depth + $urandom_range(0, 2) - 1;
          if (near < 0) near = 0;
          if (near > 63) near = 63;
          idx = 6'(near);
        end
      end else begin
        case ($urandom_range(0, 9))
          0:       op = OP_PUSH_FRONT;
          1:       op = OP_PUSH_BACK;
          2, 3, 4: op = OP_READ;
          default: op = OP_WRITE;
        endcase
        idx = 6'($urandom_range(0, 63));
      end
      if (op inside {OP_PUSH_FRONT, OP_PUSH_BACK} && gen_depth < CAPACITY) gen_depth++;
      send_word(op, idx, val, 1'($urandom_range(0, 1)), 1'b0, PREDICTED);
    end

    in_valid <= 1'b0;
    while (replies_due.size() != 0 || words_in != words_sent) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
sv/deq_pkg.sv
sv/double_ended_queue.sv
bench/double_ended_queue_test.sv
